[hdl/swi_pkg.sv]
// swi_pkg: shared types and constants of the sampled waveform interpolator
// holds the transfer payload structs, the status codes and the controller/datapath links
// no dependencies
package swi_pkg;

    // result status codes
    localparam logic [2:0] ST_INTERP = 3'd0;
    localparam logic [2:0] ST_FIRST  = 3'd1;
    localparam logic [2:0] ST_LAST   = 3'd2;
    localparam logic [2:0] ST_STORED = 3'd3;
    localparam logic [2:0] ST_ERROR  = 3'd4;

    // configuration register indexes
    localparam int          CFG_IDX_W      = 2;
    localparam logic [1:0]  CFG_TIME_SHIFT = 2'd0;
    localparam logic [1:0]  CFG_SPACING    = 2'd1;
    localparam logic [1:0]  CFG_COUNT      = 2'd2;

    // reset value of the sample spacing, 1.0 in unsigned q15.16
    localparam logic [30:0] SPACING_RESET = 31'd65536;

    // one restoring step per cycle, 33 quotient bits
    localparam int DIV_STEPS = 33;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic               func;
        logic [7:0]         sample_index;
        logic signed [31:0] sample_value;
        logic signed [31:0] query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } t_out_item;

    // table read address select
    typedef enum logic [1:0] {
        RS_ZERO = 2'd0,
        RS_LAST = 2'd1,
        RS_K    = 2'd2,
        RS_K1   = 2'd3
    } t_rsel;

    // result value source
    typedef enum logic [1:0] {
        RES_ZERO   = 2'd0,
        RES_RAM    = 2'd1,
        RES_INTERP = 2'd2
    } t_rsrc;

    // divider load source
    typedef enum logic {
        DS_TIME = 1'b0,
        DS_PROD = 1'b1
    } t_dsrc;

    typedef struct packed {
        logic       load;
        logic       ram_we;
        logic       limit_calc;
        t_rsel      rd_sel;
        logic       res_st_we;
        logic [2:0] res_st;
        logic       res_val_we;
        t_rsrc      res_src;
        logic       div_start;
        t_dsrc      div_src;
        logic       div_step;
        logic       latch_kf;
        logic       cap_y1;
        logic       cap_diff;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic idx_err;
        logic n_zero;
        logic t_le_zero;
        logic t_ge_limit;
    } t_stat;

endpackage

[hdl/swi_ram.sv]
// swi_ram: generic single write, single read ram with registered read data
// no dependencies
module swi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/swi_ctrl.sv]
// swi_ctrl: sequencing state machine of the interpolator
// depends on swi_pkg; drives the datapath through swi_pkg::t_cmd
module swi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  swi_pkg::t_stat i_stat,
    output swi_pkg::t_cmd  o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECODE = 12'b0000_0000_0010,
        S_LIMIT  = 12'b0000_0000_0100,
        S_CLAMP  = 12'b0000_0000_1000,
        S_DIV1   = 12'b0000_0001_0000,
        S_RD0    = 12'b0000_0010_0000,
        S_RD1    = 12'b0000_0100_0000,
        S_RD2    = 12'b0000_1000_0000,
        S_MUL    = 12'b0001_0000_0000,
        S_DIV2   = 12'b0010_0000_0000,
        S_FIN    = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    localparam logic [swi_pkg::CNT_W-1:0] CNT_LAST = swi_pkg::CNT_W'(swi_pkg::DIV_STEPS - 1);

    t_state                    r_state, n_state;
    logic [swi_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_out_valid, n_out_valid;
    swi_pkg::t_cmd             cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;

        cmd.load       = 1'b0;
        cmd.ram_we     = 1'b0;
        cmd.limit_calc = 1'b0;
        cmd.rd_sel     = swi_pkg::RS_ZERO;
        cmd.res_st_we  = 1'b0;
        cmd.res_st     = swi_pkg::ST_ERROR;
        cmd.res_val_we = 1'b0;
        cmd.res_src    = swi_pkg::RES_ZERO;
        cmd.div_start  = 1'b0;
        cmd.div_src    = swi_pkg::DS_TIME;
        cmd.div_step   = 1'b0;
        cmd.latch_kf   = 1'b0;
        cmd.cap_y1     = 1'b0;
        cmd.cap_diff   = 1'b0;
        cmd.out_load   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (!i_stat.func) begin
                    cmd.ram_we     = !i_stat.idx_err;
                    cmd.res_st_we  = 1'b1;
                    cmd.res_st     = i_stat.idx_err ? swi_pkg::ST_ERROR : swi_pkg::ST_STORED;
                    cmd.res_val_we = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.n_zero) begin
                    cmd.res_st_we  = 1'b1;
                    cmd.res_st     = swi_pkg::ST_ERROR;
                    cmd.res_val_we = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    cmd.limit_calc = 1'b1;
                    n_state        = S_LIMIT;
                end
            end
            S_LIMIT: begin
                cmd.res_st_we = 1'b1;
                priority if (i_stat.t_le_zero) begin
                    cmd.rd_sel = swi_pkg::RS_ZERO;
                    cmd.res_st = swi_pkg::ST_FIRST;
                    n_state    = S_CLAMP;
                end else if (i_stat.t_ge_limit) begin
                    cmd.rd_sel = swi_pkg::RS_LAST;
                    cmd.res_st = swi_pkg::ST_LAST;
                    n_state    = S_CLAMP;
                end else begin
                    cmd.res_st    = swi_pkg::ST_INTERP;
                    cmd.div_start = 1'b1;
                    cmd.div_src   = swi_pkg::DS_TIME;
                    n_cnt         = '0;
                    n_state       = S_DIV1;
                end
            end
            S_CLAMP: begin
                cmd.res_val_we = 1'b1;
                cmd.res_src    = swi_pkg::RES_RAM;
                n_state        = S_DONE;
            end
            S_DIV1: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                cmd.rd_sel   = swi_pkg::RS_K;
                cmd.latch_kf = 1'b1;
                n_state      = S_RD1;
            end
            S_RD1: begin
                cmd.rd_sel = swi_pkg::RS_K1;
                cmd.cap_y1 = 1'b1;
                n_state    = S_RD2;
            end
            S_RD2: begin
                cmd.cap_diff = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = swi_pkg::DS_PROD;
                n_cnt         = '0;
                n_state       = S_DIV2;
            end
            S_DIV2: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                cmd.res_val_we = 1'b1;
                cmd.res_src    = swi_pkg::RES_INTERP;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted item did not enter decode");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_DIV1 || r_state == S_DIV2) |-> (r_cnt == '0))
        else $error("step counter running outside a division");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

endmodule

[hdl/swi_dp.sv]
// swi_dp: datapath of the interpolator, config registers, sample table,
// shared restoring divider, multiplier and result registers
// depends on swi_pkg and swi_ram
module swi_dp #(
    parameter int MAX_SAMPLES = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  swi_pkg::t_cmd                  i_cmd,
    output swi_pkg::t_stat                 o_stat,
    input  swi_pkg::t_in_item              i_in_item,
    output swi_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_we,
    input  logic [swi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_wdata
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int LW = 31 + AW;
    localparam int XW = AW + 8;

    // configuration
    logic [31:0]        r_time_shift;
    logic [30:0]        r_spacing;
    logic [8:0]         r_count;

    // item and working registers
    logic               r_func;
    logic [7:0]         r_idx;
    logic [31:0]        r_val;
    logic [32:0]        r_t;
    logic [AW-1:0]      r_nm1;
    logic               r_nzero;
    logic [LW-1:0]      r_limit;
    logic [30:0]        r_rem;
    logic [32:0]        r_q;
    logic [AW-1:0]      r_k;
    logic [30:0]        r_frac;
    logic [31:0]        r_y1;
    logic [32:0]        r_dmag;
    logic               r_dneg;
    logic [31:0]        r_res_value;
    logic [2:0]         r_res_status;
    swi_pkg::t_out_item r_out_item;

    logic [32:0]   shifted_time;
    logic [15:0]   cnt_ext;
    logic [15:0]   cnt_sat;
    logic [15:0]   nm1_ext;
    logic [XW-1:0] idx_ext;
    logic          idx_err;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;
    logic [LW-1:0] limit_next;
    logic [63:0]   prod;
    logic [31:0]   trial;
    logic [31:0]   trial_sub;
    logic          trial_ge;
    logic [32:0]   diff;
    logic [33:0]   q_ext;
    logic [33:0]   interp_sum;
    logic [31:0]   res_value_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_shift <= '0;
            r_spacing    <= swi_pkg::SPACING_RESET;
            r_count      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                swi_pkg::CFG_TIME_SHIFT: r_time_shift <= i_cfg_wdata;
                swi_pkg::CFG_SPACING:    r_spacing    <= i_cfg_wdata[30:0];
                swi_pkg::CFG_COUNT:      r_count      <= i_cfg_wdata[8:0];
                default: begin
                end
            endcase
        end
    end

    // shifted time in 33 bits, never overflows
    assign shifted_time = {i_in_item.query_time[31], i_in_item.query_time}
                        - {r_time_shift[31], r_time_shift};

    // count saturated to the table size
    assign cnt_ext = 16'(r_count);
    assign cnt_sat = (cnt_ext > 16'(MAX_SAMPLES)) ? 16'(MAX_SAMPLES) : cnt_ext;
    assign nm1_ext = cnt_sat - 16'd1;

    assign idx_ext = XW'(r_idx);
    assign idx_err = (idx_ext >= XW'(MAX_SAMPLES));
    assign waddr   = idx_ext[AW-1:0];

    assign limit_next = LW'(r_spacing) * LW'(r_nm1);

    // one restoring division step
    assign trial     = {r_rem, r_q[32]};
    assign trial_ge  = (trial >= {1'b0, r_spacing});
    assign trial_sub = trial - {1'b0, r_spacing};

    assign prod = 64'(r_dmag) * 64'(r_frac);
    assign diff = {rdata[31], rdata} - {r_y1[31], r_y1};

    assign q_ext      = {1'b0, r_q};
    assign interp_sum = {{2{r_y1[31]}}, r_y1} + (r_dneg ? (34'd0 - q_ext) : q_ext);

    always_comb begin
        unique case (i_cmd.rd_sel)
            swi_pkg::RS_ZERO: raddr = '0;
            swi_pkg::RS_LAST: raddr = r_nm1;
            swi_pkg::RS_K:    raddr = r_q[AW-1:0];
            swi_pkg::RS_K1:   raddr = r_k + AW'(1);
        endcase
    end

    always_comb begin
        unique case (i_cmd.res_src)
            swi_pkg::RES_RAM:    res_value_next = rdata;
            swi_pkg::RES_INTERP: res_value_next = interp_sum[31:0];
            default:             res_value_next = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_in_item.func;
            r_idx   <= i_in_item.sample_index;
            r_val   <= i_in_item.sample_value;
            r_t     <= shifted_time;
            r_nm1   <= nm1_ext[AW-1:0];
            r_nzero <= (r_count == 9'd0);
        end
        if (i_cmd.limit_calc) begin
            r_limit <= limit_next;
        end
        if (i_cmd.div_start) begin
            if (i_cmd.div_src == swi_pkg::DS_PROD) begin
                r_rem <= prod[63:33];
                r_q   <= prod[32:0];
            end else begin
                r_rem <= '0;
                r_q   <= r_t;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial_sub[30:0] : trial[30:0];
            r_q   <= {r_q[31:0], trial_ge};
        end
        if (i_cmd.latch_kf) begin
            r_k    <= r_q[AW-1:0];
            r_frac <= r_rem;
        end
        if (i_cmd.cap_y1) begin
            r_y1 <= rdata;
        end
        if (i_cmd.cap_diff) begin
            r_dneg <= diff[32];
            r_dmag <= diff[32] ? (33'd0 - diff) : diff;
        end
        if (i_cmd.res_st_we) begin
            r_res_status <= i_cmd.res_st;
        end
        if (i_cmd.res_val_we) begin
            r_res_value <= res_value_next;
        end
        if (i_cmd.out_load) begin
            r_out_item.value  <= r_res_value;
            r_out_item.status <= r_res_status;
        end
    end

    swi_ram #(
        .WIDTH (32),
        .DEPTH (MAX_SAMPLES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (waddr),
        .i_wdata (r_val),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_stat.func       = r_func;
    assign o_stat.idx_err    = idx_err;
    assign o_stat.n_zero     = r_nzero;
    assign o_stat.t_le_zero  = r_t[32] || (r_t == 33'd0);
    assign o_stat.t_ge_limit = (64'(r_t[31:0]) >= 64'(r_limit));
    assign o_out_item        = r_out_item;

    a_seg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.latch_kf |-> (r_q < 33'(r_nm1)))
        else $error("segment index past the last segment");

    a_quot_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_val_we && i_cmd.res_src == swi_pkg::RES_INTERP) |-> (r_q <= r_dmag))
        else $error("interpolation step exceeds sample difference");

endmodule

[hdl/sampled_waveform_interpolator_unit.sv]
// sampled_waveform_interpolator_unit: top level of the piecewise linear waveform interpolator
// depends on swi_pkg, swi_ctrl, swi_dp (and swi_ram inside swi_dp)
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    i_in_item   (swi_pkg::t_in_item)
//   out       output     o_out_valid / i_out_ready  o_out_item  (swi_pkg::t_out_item)
//   cfg       input      i_cfg_we, no wait          i_cfg_index, i_cfg_wdata
//
// a sample write or an error is answered straight from decode, a clamped evaluation after
//   one table read, an interpolation after two passes of the single shared restoring
//   divider, one quotient bit a cycle
// one item at a time; the input reopens the cycle after the result is loaded into
//   the output register, so a result may still wait there while the next item is taken
// a result stalled on i_out_ready holds the controller in its final state only
// synchronous active-low reset clears the controller, the output valid flag and the
//   config registers; the sample table is not cleared and holds garbage until written
module sampled_waveform_interpolator_unit #(
    parameter int MAX_SAMPLES = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // item input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  swi_pkg::t_in_item              i_in_item,

    // result output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output swi_pkg::t_out_item             o_out_item,

    // configuration write port: 0 time shift, 1 sample spacing, 2 sample count
    input  logic                           i_cfg_we,
    input  logic [swi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_wdata
);

    swi_pkg::t_cmd  cmd;
    swi_pkg::t_stat stat;

    // sequencing: decode, limit check, then a clamped table read or division, table reads, multiply, division, add
    swi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // arithmetic, sample table and output register
    swi_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

endmodule

[verif/sampled_waveform_interpolator_unit_tb.sv]
// sampled_waveform_interpolator_unit_tb: self-checking testbench of the waveform interpolator
// drives the item, result and configuration ports; a scoreboard class predicts every result
// depends on swi_pkg and sampled_waveform_interpolator_unit
module sampled_waveform_interpolator_unit_tb;

    localparam int TABLE_DEPTH   = 256;
    localparam int SETTLE_CYCLES = 80;    // a little over the interpolation latency
    localparam int LONG_HOLD     = 400;   // long output back-pressure, in cycles
    localparam int PHASE_ITEMS   = 25;
    localparam int PHASES        = 8;

    // keeps its own sample table and register copies, predicts one result per input transfer
    class interp_scoreboard;
        logic signed [31:0] sample_mem [TABLE_DEPTH];
        logic signed [31:0] shift;
        logic [30:0]        spacing;
        logic [8:0]         count;
        swi_pkg::t_out_item awaited [$];
        int                 mismatches;
        int                 accepted_items;
        int                 results_seen;
        int                 status_tally [8];

        function new();
            foreach (sample_mem[i]) sample_mem[i] = '0;
            foreach (status_tally[i]) status_tally[i] = 0;
            shift          = '0;
            spacing        = swi_pkg::SPACING_RESET;
            count          = '0;
            mismatches     = 0;
            accepted_items = 0;
            results_seen   = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] data);
            case (idx)
                swi_pkg::CFG_TIME_SHIFT: shift = data;
                swi_pkg::CFG_SPACING:    spacing = data[30:0];
                swi_pkg::CFG_COUNT:      count = data[8:0];
                default: ;
            endcase
        endfunction

        function swi_pkg::t_out_item interpolate(swi_pkg::t_in_item item);
            swi_pkg::t_out_item res;
            int unsigned        n;
            longint             t;
            longint             sp;
            longint             lim;
            longint             k;
            longint             frac;
            longint             y_lo;
            longint             y_hi;
            longint             acc;
            res = '0;
            if (!item.func) begin
                if (int'(item.sample_index) >= TABLE_DEPTH) begin
                    res.status = swi_pkg::ST_ERROR;
                end else begin
                    sample_mem[item.sample_index] = item.sample_value;
                    res.status = swi_pkg::ST_STORED;
                end
                return res;
            end
            n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
            if (n == 0) begin
                res.status = swi_pkg::ST_ERROR;
                return res;
            end
            t   = longint'($signed(item.query_time)) - longint'($signed(shift));
            sp  = longint'(spacing);
            lim = sp * longint'(n - 1);
            if (t <= 0) begin
                res.value  = sample_mem[0];
                res.status = swi_pkg::ST_FIRST;
            end else if (t >= lim) begin
                res.value  = sample_mem[n - 1];
                res.status = swi_pkg::ST_LAST;
            end else begin
                k          = t / sp;
                frac       = t - k * sp;
                y_lo       = longint'(sample_mem[int'(k)]);
                y_hi       = longint'(sample_mem[int'(k) + 1]);
                acc        = y_lo + ((y_hi - y_lo) * frac) / sp;
                res.value  = acc[31:0];
                res.status = swi_pkg::ST_INTERP;
            end
            return res;
        endfunction

        function void note_input(swi_pkg::t_in_item item);
            awaited.push_back(interpolate(item));
            accepted_items++;
        endfunction

        function void check_result(swi_pkg::t_out_item got);
            swi_pkg::t_out_item want;
            results_seen++;
            if (awaited.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result %0d: value %h status %0d",
                             results_seen, got.value, got.status);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            status_tally[want.status]++;
            if (got.value !== want.value || got.status !== want.status) begin
                if (mismatches < 10)
                    $display("result %0d wrong: value %h status %0d, expected value %h status %0d",
                             results_seen, got.value, got.status, want.value, want.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    swi_pkg::t_in_item             i_in_item;
    logic                          o_out_valid;
    logic                          i_out_ready;
    swi_pkg::t_out_item            o_out_item;
    logic                          i_cfg_we;
    logic [swi_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]                   i_cfg_wdata;

    interp_scoreboard sb = new();

    // random idling on both sides, switched off for some phases
    bit idling = 1'b1;
    // set by the stimulus to make the receiver hold off for a long stretch
    bit long_hold_request = 1'b0;

    sampled_waveform_interpolator_unit #(
        .MAX_SAMPLES (TABLE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // period of two time units
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- value generators

    // extremes, small signed values near zero, or anything at all
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 2047)) - 32'd1024;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] random_spacing();
        case ($urandom_range(0, 5))
            0: return 31'd1;
            1: return swi_pkg::SPACING_RESET;
            2: return 31'h7FFF_FFFF;
            3: return 31'($urandom_range(1, 1 << 20));
            default: return 31'($urandom);
        endcase
    endfunction

    // mostly a usable table length, now and then none or more than the table holds
    function automatic logic [8:0] random_count();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd256;
            3: return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(2, 256));
        endcase
    endfunction

    // writes keep every entry defined; most evaluations land in or just around the table span
    function automatic swi_pkg::t_in_item random_item();
        swi_pkg::t_in_item it;
        int unsigned       n;
        longint unsigned   span;
        longint            t_abs;
        it.func         = ($urandom_range(0, 3) != 0);
        it.sample_index = 8'($urandom);
        it.sample_value = random_word();
        it.query_time   = random_word();
        if (it.func && $urandom_range(0, 9) < 7) begin
            n = (sb.count > TABLE_DEPTH) ? TABLE_DEPTH : sb.count;
            if (n == 0) n = 1;
            span  = longint'(sb.spacing) * (n + 1) + 1;
            t_abs = longint'({$urandom, $urandom} % span) - longint'(sb.spacing)
                    + longint'($signed(sb.shift));
            it.query_time = t_abs[31:0];
        end
        return it;
    endfunction

    // ---------------------------------------------------------------- drivers

    // valid stays up between back-to-back transfers, so it is only lowered for a gap
    task automatic send_item(input swi_pkg::t_in_item item);
        int unsigned gap;
        gap = idling ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(item);
    endtask

    task automatic send_write(input logic [7:0] idx, input logic [31:0] data);
        swi_pkg::t_in_item it;
        it.func         = 1'b0;
        it.sample_index = idx;
        it.sample_value = data;
        it.query_time   = $urandom;
        send_item(it);
    endtask

    task automatic send_eval(input logic [31:0] when);
        swi_pkg::t_in_item it;
        it.func         = 1'b1;
        it.sample_index = 8'($urandom);
        it.sample_value = $urandom;
        it.query_time   = when;
        send_item(it);
    endtask

    // stop offering, wait for every outstanding result, then idle for SETTLE_CYCLES
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // all three registers on consecutive edges, only while the block is idle
    task automatic configure(input logic [31:0] shift, input logic [30:0] spacing,
                             input logic [8:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= swi_pkg::CFG_TIME_SHIFT;
        i_cfg_wdata <= shift;
        @(posedge i_clk);
        sb.set_register(swi_pkg::CFG_TIME_SHIFT, shift);
        i_cfg_index <= swi_pkg::CFG_SPACING;
        i_cfg_wdata <= {1'b0, spacing};
        @(posedge i_clk);
        sb.set_register(swi_pkg::CFG_SPACING, {1'b0, spacing});
        i_cfg_index <= swi_pkg::CFG_COUNT;
        i_cfg_wdata <= {23'd0, count};
        @(posedge i_clk);
        sb.set_register(swi_pkg::CFG_COUNT, {23'd0, count});
        i_cfg_we    <= 1'b0;
    endtask

    // ---------------------------------------------------------------- result side

    // receiver: a random stall before each result, plus the occasional long hold-off
    initial begin : receiver
        int unsigned stall;
        forever begin
            if (long_hold_request) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_request = 1'b0;
            end
            stall = idling ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // every output transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_item);
    end

    // ---------------------------------------------------------------- stimulus

    initial begin : stimulus
        int phase;
        int i;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= swi_pkg::CFG_TIME_SHIFT;
        i_cfg_wdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table after reset: evaluations are errors
        send_eval(32'd0);
        send_eval(32'h8000_0000);

        // extreme samples at both ends of the table and at the first entries
        send_write(8'd0, 32'h7FFF_FFFF);
        send_write(8'd1, 32'h8000_0000);
        send_write(8'd2, 32'h0001_8000);
        send_write(8'd255, 32'h8000_0000);
        settle();

        // single sample: always clamped, first or last
        configure(32'd0, swi_pkg::SPACING_RESET, 9'd1);
        send_eval(-32'sd5);
        send_eval(32'd0);
        send_eval(32'h7FFF_FFFF);
        settle();

        // two samples of opposite extremes, widest possible difference
        configure(32'd0, swi_pkg::SPACING_RESET, 9'd2);
        send_eval(32'd32768);
        send_eval(32'd1);
        send_eval(32'd65535);
        send_eval(32'd65536);
        settle();

        // largest positive shift with the most negative time: far below zero
        configure(32'h7FFF_FFFF, swi_pkg::SPACING_RESET, 9'd3);
        send_eval(32'h8000_0000);
        settle();

        // most negative shift, widest spacing: shifted time needs the 33rd bit
        configure(32'h8000_0000, 31'h7FFF_FFFF, 9'd3);
        send_eval(32'h7FFF_FFFF);
        send_eval(32'h7FFF_FFFD);
        send_eval(32'd0);
        settle();

        // zero spacing: any positive time clamps to the last sample
        configure(32'd0, 31'd0, 9'd3);
        send_eval(32'd1);
        send_eval(32'd0);
        settle();

        // count above the table size saturates to the full table
        configure(32'd0, 31'd0, 9'h1FF);
        send_eval(32'd5);
        settle();

        // fill the whole table so that any later setting reads only written entries
        for (i = TABLE_DEPTH - 1; i >= 0; i--)
            send_write(8'(i), random_word());
        settle();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: configure(32'd0, swi_pkg::SPACING_RESET, 9'd256);
                1: configure(32'h8000_0000, 31'h7FFF_FFFF, 9'd2);
                2: configure(32'h7FFF_FFFF, 31'd1, 9'h1FF);
                3: configure(random_word(), 31'd0, random_count());
                default: configure(random_word(), random_spacing(), random_count());
            endcase
            // one phase with no idling on either side
            idling = (phase != 4);
            // receiver backs off while the sender keeps offering, so the input stalls
            if (phase == 5)
                long_hold_request = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // sender pauses mid-phase until every result is back
                if (phase == 6 && i == PHASE_ITEMS / 2)
                    settle();
                send_item(random_item());
            end
            settle();
        end
        idling = 1'b1;

        $display("covered %0d input transfers and %0d results over reset, directed cases",
                 sb.accepted_items, sb.results_seen);
        $display("  and %0d setting phases; by kind: %0d interpolated, %0d first, %0d last, %0d stored, %0d errors",
                 PHASES, sb.status_tally[swi_pkg::ST_INTERP], sb.status_tally[swi_pkg::ST_FIRST],
                 sb.status_tally[swi_pkg::ST_LAST], sb.status_tally[swi_pkg::ST_STORED],
                 sb.status_tally[swi_pkg::ST_ERROR]);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
